### rtl/core/shcl_pkg.sv
`timescale 1ns / 1ps
package shcl_pkg;
  localparam int unsigned PoolEntries = 1024;
  localparam int unsigned BucketCount = 1024;
  localparam int unsigned MaxMatches  = 64;
  localparam int unsigned LinkW   = $clog2(PoolEntries + 1);
  localparam int unsigned PoolAw  = (PoolEntries > 1) ? $clog2(PoolEntries) : 1;
  localparam int unsigned BucketAw = (BucketCount > 1) ? $clog2(BucketCount) : 1;
  localparam int unsigned MatchCntW = $clog2(MaxMatches + 1);
  localparam logic [31:0] PrimeX = 32'd73856093;
  localparam logic [31:0] PrimeY = 32'd19349663;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpQuery = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StAdded   = 3'd0,
    StDropped = 3'd1,
    StCleared = 3'd2,
    StMatch   = 3'd3,
    StNone    = 3'd4
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture request, start hash multiply
    logic hash;        // register hash
    logic head_rd;     // registered bucket head read
    logic add_wr;      // write entry and bucket head
    logic clr_step;    // clear one bucket
    logic clr_start;
    logic walk_start;  // link <= head
    logic ent_rd;      // read entry at link
    logic walk_step;   // link <= next, count
    logic emit_match;  // record pending match
    logic hold_clr;    // clear pending match
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic pool_full;
    logic clr_done;
    logic link_null;
    logic walk_done;   // step bound reached
    logic hit;
    logic cnt_full;    // MaxMatches already emitted
    logic pend;        // a match is held back
  } stat_t;
endpackage

### rtl/core/shcl_datapath.sv
`timescale 1ns / 1ps
module shcl_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        op_i,
  input  logic [15:0]       cell_x_i,
  input  logic [15:0]       cell_y_i,
  input  logic [15:0]       object_id_i,
  input  shcl_pkg::cmd_t    cmd_i,
  output shcl_pkg::stat_t   stat_o,
  output logic [15:0]       pend_id_o
);
  import shcl_pkg::*;

  logic [LinkW-1:0]    bucket_head_q [BucketCount];
  logic [31:0]         entry_cell_q [PoolEntries];
  logic [15:0]         entry_id_q [PoolEntries];
  logic [LinkW-1:0]    entry_next_q [PoolEntries];

  logic [1:0]  op_q;
  logic [31:0] cell_q, px_q, py_q;
  logic [15:0] id_q;
  logic [BucketAw-1:0] hash_q, clr_q;
  logic [LinkW-1:0] fill_q, head_q, link_q;
  logic [LinkW:0]   steps_q;
  logic [MatchCntW-1:0] cnt_q;
  logic [31:0] rd_cell_q;
  logic [15:0] rd_id_q;
  logic [LinkW-1:0] rd_next_q;
  logic pend_q;
  logic [15:0] pend_id_q;
  logic [PoolAw-1:0] wr_idx, rd_idx;
  logic [31:0] hval;

  assign wr_idx = fill_q[PoolAw-1:0];
  assign rd_idx = PoolAw'(link_q - LinkW'(1));
  assign hval   = (px_q ^ py_q) & 32'(BucketCount - 1);

  // clear sweep: head marked invalid via separate valid-free epoch is avoided;
  // heads are cleared one bucket per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      cell_q <= {cell_y_i, cell_x_i};
      id_q   <= object_id_i;
      px_q   <= {{16{cell_x_i[15]}}, cell_x_i} * PrimeX;
      py_q   <= {{16{cell_y_i[15]}}, cell_y_i} * PrimeY;
    end
    if (cmd_i.hash) hash_q <= hval[BucketAw-1:0];
    if (cmd_i.head_rd) head_q <= bucket_head_q[hash_q];
    if (cmd_i.add_wr) begin
      entry_cell_q[wr_idx] <= cell_q;
      entry_id_q[wr_idx]   <= id_q;
      entry_next_q[wr_idx] <= head_q;
      bucket_head_q[hash_q] <= fill_q + LinkW'(1);
    end else if (cmd_i.clr_step) begin
      bucket_head_q[clr_q] <= '0;
    end
    if (cmd_i.ent_rd) begin
      rd_cell_q <= entry_cell_q[rd_idx];
      rd_id_q   <= entry_id_q[rd_idx];
      rd_next_q <= entry_next_q[rd_idx];
    end
    if (cmd_i.emit_match) pend_id_q <= rd_id_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      clr_q   <= '0;
      link_q  <= '0;
      steps_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.add_wr) fill_q <= fill_q + LinkW'(1);
      if (cmd_i.clr_start) begin
        clr_q  <= '0;
        fill_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= clr_q + BucketAw'(1);
      end
      if (cmd_i.walk_start) begin
        link_q  <= head_q;
        steps_q <= '0;
        cnt_q   <= '0;
        pend_q  <= 1'b0;
      end else begin
        if (cmd_i.walk_step) begin
          link_q  <= rd_next_q;
          steps_q <= steps_q + (LinkW+1)'(1);
        end
        if (cmd_i.emit_match) begin
          pend_q <= 1'b1;
          cnt_q  <= cnt_q + MatchCntW'(1);
        end else if (cmd_i.hold_clr) begin
          pend_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.op        = op_e'(op_q);
  assign stat_o.pool_full = (fill_q >= LinkW'(PoolEntries));
  assign stat_o.clr_done  = (clr_q == BucketAw'(BucketCount - 1));
  assign stat_o.link_null = (link_q == '0) || (link_q > LinkW'(PoolEntries));
  assign stat_o.walk_done = (steps_q >= (LinkW+1)'(PoolEntries));
  assign stat_o.hit       = (rd_cell_q == cell_q);
  assign stat_o.cnt_full  = (cnt_q >= MatchCntW'(MaxMatches));
  assign stat_o.pend      = pend_q;
  assign pend_id_o        = pend_id_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |-> !stat_o.pool_full) else $error("add into full pool");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_wr |=> fill_q == $past(fill_q) + LinkW'(1)) else $error("fill not bumped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ent_rd |-> !stat_o.link_null) else $error("read of null link");
endmodule

### rtl/core/shcl_ctrl.sv
`timescale 1ns / 1ps
module shcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [2:0]        status_o,
  output logic [15:0]       match_id_o,
  output logic              last_o,
  output logic              truncated_o,
  output shcl_pkg::cmd_t    cmd_o,
  input  shcl_pkg::stat_t   stat_i,
  input  logic [15:0]       pend_id_i
);
  import shcl_pkg::*;

  typedef enum logic [3:0] {
    SInit, SIdle, SHash, SHead, SDisp, SAdd, SClr, SWalk, SRead, SCheck, SOut
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q;
  logic [2:0] ost_q, ost_d;
  logic [15:0] oid_q, oid_d;
  logic olast_q, otrunc_q, olast_d, otrunc_d;
  logic out_load;
  logic back_q; // walk ended on a hit past the match limit

  logic out_free;
  assign out_free = !ovalid_q || ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      // bucket heads swept to empty after reset
      SInit: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = SIdle;
      end
      SIdle: if (valid_i) begin cmd_o.load = 1'b1; state_d = SHash; end
      SHash: begin cmd_o.hash = 1'b1; state_d = SHead; end
      SHead: begin cmd_o.head_rd = 1'b1; state_d = SDisp; end
      SDisp: begin
        case (stat_i.op)
          OpClear: begin cmd_o.clr_start = 1'b1; state_d = SClr; end
          OpAdd:   state_d = SAdd;
          OpQuery: begin cmd_o.walk_start = 1'b1; state_d = SWalk; end
          default: state_d = SIdle;
        endcase
      end
      SAdd: if (out_free) begin
        cmd_o.add_wr = !stat_i.pool_full;
        state_d = SIdle;
      end
      SClr: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = SOut;
      end
      SWalk: begin
        if (stat_i.link_null || stat_i.walk_done) state_d = SOut;
        else begin cmd_o.ent_rd = 1'b1; state_d = SCheck; end
      end
      SCheck: begin
        if (stat_i.hit && stat_i.cnt_full) state_d = SOut;
        else if (stat_i.hit && stat_i.pend) begin
          if (out_free) begin
            cmd_o.hold_clr = 1'b1;
            state_d = SRead;
          end
        end else begin
          cmd_o.emit_match = stat_i.hit;
          cmd_o.walk_step  = 1'b1;
          state_d = SWalk;
        end
      end
      SRead: begin
        cmd_o.emit_match = 1'b1;
        cmd_o.walk_step  = 1'b1;
        state_d = SWalk;
      end
      SOut: if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // next result register contents
  always_comb begin
    out_load = 1'b0;
    ost_d    = StNone;
    oid_d    = '0;
    olast_d  = 1'b1;
    otrunc_d = 1'b0;
    case (state_q)
      SAdd: if (out_free) begin
        out_load = 1'b1;
        ost_d    = stat_i.pool_full ? StDropped : StAdded;
      end
      SCheck: if (stat_i.hit && stat_i.pend && !stat_i.cnt_full && out_free) begin
        out_load = 1'b1;
        ost_d    = StMatch;
        oid_d    = pend_id_i;
        olast_d  = 1'b0;
      end
      SOut: if (out_free) begin
        out_load = 1'b1;
        if (stat_i.op == OpClear) begin
          ost_d = StCleared;
        end else if (stat_i.pend) begin
          ost_d    = StMatch;
          oid_d    = pend_id_i;
          otrunc_d = stat_i.cnt_full && stat_i.hit && !stat_i.link_null
                     && !stat_i.walk_done && back_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SInit;
      ovalid_q <= 1'b0;
      ost_q    <= '0;
      oid_q    <= '0;
      olast_q  <= 1'b0;
      otrunc_q <= 1'b0;
      back_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
        ost_q    <= ost_d;
        oid_q    <= oid_d;
        olast_q  <= olast_d;
        otrunc_q <= otrunc_d;
      end else if (ovalid_q && ready_i) begin
        ovalid_q <= 1'b0;
      end
      // held until SOut hands off its result
      if (state_q == SCheck && stat_i.hit && stat_i.cnt_full) back_q <= 1'b1;
      else if (state_q == SOut && out_free) back_q <= 1'b0;
    end
  end

  assign ready_o     = (state_q == SIdle);
  assign valid_o     = ovalid_q;
  assign status_o    = ost_q;
  assign match_id_o  = oid_q;
  assign last_o      = olast_q;
  assign truncated_o = otrunc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_match && stat_i.pend) |-> cmd_o.hold_clr == 1'b0)
    else $error("match overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> state_q == SIdle) else $error("ready outside idle");
endmodule

### rtl/core/spatial_hash_cell_list.sv
`timescale 1ns / 1ps
// After accept: capture with hash multiply, hash, bucket head read, dispatch;
// then an add writes its entry, a clear sweeps every bucket, a query reads and
// checks each chain entry; results wait while the output is stalled. One request
// at a time: the next can be accepted in the cycle after the last result of the
// current one is loaded. Reset: rst_ni asynchronous active low; afterwards the
// bucket heads are swept to empty, one per cycle, with ready_o low until done.
module spatial_hash_cell_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  op_i,
  input  logic signed [15:0] cell_x_i,
  input  logic signed [15:0] cell_y_i,
  input  logic [15:0] object_id_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [2:0]  status_o,
  output logic [15:0] match_id_o,
  output logic        last_o,
  output logic        truncated_o
);
  import shcl_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [15:0] pend_id;

  shcl_datapath u_dp (
    .clk_i, .rst_ni, .op_i,
    .cell_x_i(cell_x_i), .cell_y_i(cell_y_i),
    .object_id_i, .cmd_i(cmd), .stat_o(stat), .pend_id_o(pend_id)
  );

  shcl_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .ready_o, .valid_o, .ready_i,
    .status_o, .match_id_o, .last_o, .truncated_o,
    .cmd_o(cmd), .stat_i(stat), .pend_id_i(pend_id)
  );
endmodule

### bench/spatial_hash_cell_list_tb.sv
`timescale 1ns / 1ps
module spatial_hash_cell_list_tb;
  import shcl_pkg::*;

  typedef struct {
    status_e     st;
    logic [15:0] id;
    bit          last;
    bit          trunc;
  } cell_result_t;

  class cell_list_board;
    bit [10:0]    heads[BucketCount];
    logic [31:0]  cells[PoolEntries];
    logic [15:0]  ids[PoolEntries];
    bit [10:0]    nexts[PoolEntries];
    int unsigned  fill;
    cell_result_t awaited[$];
    int           errors;

    function int unsigned bucket_of(logic [15:0] x, logic [15:0] y);
      logic [31:0] hx, hy;
      hx = {{16{x[15]}}, x} * PrimeX;
      hy = {{16{y[15]}}, y} * PrimeY;
      return (hx ^ hy) & (BucketCount - 1);
    endfunction

    function void push(status_e st, logic [15:0] id, bit trunc);
      cell_result_t r;
      r.st = st; r.id = id; r.last = 1'b1; r.trunc = trunc;
      awaited.push_back(r);
    endfunction

    // predict results of one accepted request
    function void note_request(op_e op, logic [15:0] x, logic [15:0] y,
                               logic [15:0] id);
      int unsigned h, idx, steps, n;
      bit [10:0] link;
      bit more;
      cell_result_t found[$];
      cell_result_t r;
      case (op)
        OpClear: begin
          foreach (heads[i]) heads[i] = '0;
          fill = 0;
          push(StCleared, '0, 1'b0);
        end
        OpAdd: begin
          if (fill >= PoolEntries) begin
            push(StDropped, '0, 1'b0);
          end else begin
            h = bucket_of(x, y);
            cells[fill] = {y, x};
            ids[fill] = id;
            nexts[fill] = heads[h];
            heads[h] = 11'(fill + 1);
            fill++;
            push(StAdded, '0, 1'b0);
          end
        end
        OpQuery: begin
          link = heads[bucket_of(x, y)];
          steps = 0; n = 0; more = 0;
          while (link != 0 && steps < PoolEntries) begin
            idx = link - 1;
            if (cells[idx] == {y, x}) begin
              if (n >= MaxMatches) begin
                more = 1;
                break;
              end
              r.st = StMatch; r.id = ids[idx]; r.last = 0; r.trunc = 0;
              found.push_back(r);
              n++;
            end
            link = nexts[idx];
            steps++;
          end
          if (n == 0) begin
            push(StNone, '0, 1'b0);
          end else begin
            found[n-1].last = 1'b1;
            found[n-1].trunc = more;
            foreach (found[i]) awaited.push_back(found[i]);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [2:0] st, logic [15:0] id, logic last,
                               logic trunc);
      cell_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%h last=%b trunc=%b",
                 $realtime, st, id, last, trunc);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (st !== e.st || id !== e.id || last !== e.last || trunc !== e.trunc) begin
        $display("%0t: mismatch expected status=%0d id=%h last=%b trunc=%b, got status=%0d id=%h last=%b trunc=%b",
                 $realtime, e.st, e.id, e.last, e.trunc, st, id, last, trunc);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        valid_i, ready_o, valid_o, ready_i;
  logic [1:0]  op_i;
  logic signed [15:0] cell_x_i, cell_y_i;
  logic [15:0] object_id_i;
  logic [2:0]  status_o;
  logic [15:0] match_id_o;
  logic        last_o, truncated_o;

  cell_list_board board;
  int unsigned tx_idle_pct, rx_idle_pct;
  bit          long_hold;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  spatial_hash_cell_list uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // request and result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i && ready_o)
        board.note_request(op_e'(op_i), cell_x_i, cell_y_i, object_id_i);
      if (valid_o && ready_i)
        board.check_result(status_o, match_id_o, last_o, truncated_o);
    end
  end

  // receiver with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      ready_i <= 1'b0;
    end else if (long_hold) begin
      long_hold = 1'b0;
      hold_left = 400;
      ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ready_i <= 1'b0;
    end else begin
      ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 6000) begin
      $display("spatial_hash_cell_list regression: fail");
      $finish;
    end
  end

  task automatic send(op_e op, logic [15:0] x, logic [15:0] y, logic [15:0] id);
    if ($urandom_range(99) < tx_idle_pct) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    op_i <= op;
    cell_x_i <= x;
    cell_y_i <= y;
    object_id_i <= id;
    do @(posedge clk_i); while (!ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic random_run(int unsigned count);
    logic [15:0] x, y;
    int unsigned pick;
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        x = 16'($urandom); y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(6)) - 16'd3; y = 16'($urandom_range(6)) - 16'd3;
      end
      pick = $urandom_range(99);
      if (pick < 3) send(OpClear, 16'($urandom), 16'($urandom), 16'($urandom));
      else if (pick < 50) send(OpAdd, x, y, 16'($urandom));
      else if (pick < 95) send(OpQuery, x, y, 16'($urandom));
      else send(OpNone, x, y, 16'($urandom));
    end
  endtask

  initial begin
    board = new();
    rst_ni = 1'b0;
    valid_i = 1'b0;
    ready_i = 1'b0;
    op_i = OpClear;
    cell_x_i = '0;
    cell_y_i = '0;
    object_id_i = '0;
    tx_idle_pct = 9;
    rx_idle_pct = 69;
    long_hold = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // table is empty straight out of reset
    send(OpQuery, '0, '0, '0);
    send(OpClear, '0, '0, '0);
    send(OpAdd, 16'h8000, 16'h7fff, 16'h0000);
    send(OpAdd, 16'h7fff, 16'h8000, 16'hffff);
    send(OpAdd, 16'hffff, 16'hffff, 16'h5a5a);
    send(OpAdd, 16'h8000, 16'h7fff, 16'ha5a5);
    send(OpQuery, 16'h8000, 16'h7fff, '0);
    send(OpQuery, 16'h7fff, 16'h8000, 16'hffff);
    send(OpQuery, 16'hffff, 16'hffff, '0);
    send(OpQuery, 16'h0001, 16'h0002, '0);
    send(OpNone, 16'h8000, 16'h7fff, 16'hffff);
    send(OpQuery, 16'h8000, 16'h7fff, '0);
    send(OpClear, 16'hffff, 16'hffff, 16'hffff);
    send(OpQuery, 16'h8000, 16'h7fff, '0);

    // exactly the match limit, then one over it
    for (int i = 0; i < MaxMatches; i++) send(OpAdd, 16'd5, 16'hfffb, 16'(i));
    send(OpQuery, 16'd5, 16'hfffb, '0);
    send(OpAdd, 16'd5, 16'hfffb, 16'hbeef);
    send(OpQuery, 16'd5, 16'hfffb, '0);
    drain();

    random_run(43);
    drain();
    tx_idle_pct = 69;
    rx_idle_pct = 9;
    random_run(43);
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold = 1'b1;
    random_run(43);
    drain();

    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("spatial_hash_cell_list regression: pass");
    end else begin
      $display("spatial_hash_cell_list regression: fail");
    end
    $finish;
  end
endmodule

### spatial_hash_cell_list.f
rtl/core/shcl_pkg.sv
rtl/core/shcl_datapath.sv
rtl/core/shcl_ctrl.sv
rtl/core/spatial_hash_cell_list.sv
bench/spatial_hash_cell_list_tb.sv
